/* src/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as cond.
`define ASSERT_IMPLIES(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after cond.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* src/csem_pkg.sv */
package csem_pkg;

   // Request codes as they arrive on the input channel
   localparam logic [1:0] CMD_WAIT   = 2'd0;
   localparam logic [1:0] CMD_SIGNAL = 2'd1;
   localparam logic [1:0] CMD_INIT   = 2'd2;

   // Count limits (16-bit two's complement)
   localparam logic [15:0] CNT_MAX = 16'h7FFF;
   localparam logic [15:0] CNT_MIN = 16'h8000;

   // Command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = 1;
   localparam int CMDQ_CNT_W = 2;

   // Result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef enum logic [1:0] {
      OP_WAIT   = 2'd0,
      OP_SIGNAL = 2'd1,
      OP_INIT   = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  sem_id;
      logic [5:0]  task_id;
      logic [14:0] initial_count;
   } req_type;

   typedef struct packed {
      logic [5:0] release_task;
      logic       last;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  sem_id;
      logic [5:0]  task_id;
      logic [14:0] initial_count;
   } cmd_type;

endpackage

/* src/csem_front.sv */
`include "assert_macros.svh"

module csem_front #(
   parameter int TASKS      = 64,
   parameter int SEMAPHORES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  csem_pkg::req_type  req_data,
   output logic               cmd_valid,
   input  logic               cmd_pop,
   output csem_pkg::cmd_type  cmd_data
);

   csem_pkg::cmd_type                   q_mem [csem_pkg::CMDQ_DEPTH];
   logic [csem_pkg::CMDQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [csem_pkg::CMDQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [csem_pkg::CMDQ_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                                accept;
   logic                                legal;
   logic                                keep;
   csem_pkg::cmd_type                   entry;

   assign req_full  = (cnt_ff == csem_pkg::CMDQ_CNT_W'(csem_pkg::CMDQ_DEPTH));
   assign accept    = req_push && !req_full;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_mem[rd_ptr_ff];

   // Classify: decode the command, drop unknown codes and out-of-range ids
   always_comb begin
      entry.sem_id        = req_data.sem_id;
      entry.task_id       = req_data.task_id;
      entry.initial_count = req_data.initial_count;
      entry.op            = csem_pkg::OP_WAIT;
      legal               = 1'b1;
      case (req_data.command)
         csem_pkg::CMD_WAIT:   entry.op = csem_pkg::OP_WAIT;
         csem_pkg::CMD_SIGNAL: entry.op = csem_pkg::OP_SIGNAL;
         csem_pkg::CMD_INIT:   entry.op = csem_pkg::OP_INIT;
         default:              legal    = 1'b0;
      endcase
      if (9'(req_data.sem_id) >= 9'(SEMAPHORES) || 9'(req_data.task_id) >= 9'(TASKS)) begin
         legal = 1'b0;
      end
   end

   assign keep      = accept && legal;
   assign wr_ptr_in = keep ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign cnt_in    = cnt_ff + csem_pkg::CMDQ_CNT_W'(keep) - csem_pkg::CMDQ_CNT_W'(cmd_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         q_mem[wr_ptr_ff] <= entry;
      end
   end

   `ASSERT_IMPLIES(a_front_pop_valid, clock, reset, cmd_pop, cmd_valid)
   `ASSERT_IMPLIES(a_front_cnt_bound, clock, reset, 1'b1,
                   cnt_ff <= csem_pkg::CMDQ_CNT_W'(csem_pkg::CMDQ_DEPTH))

endmodule

/* src/csem_rsp_q.sv */
`include "assert_macros.svh"

module csem_rsp_q (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  csem_pkg::rsp_type  push_data,
   output logic               room2,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output csem_pkg::rsp_type  rsp_data
);

   csem_pkg::rsp_type                q_mem [csem_pkg::RSP_DEPTH];
   logic [csem_pkg::RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [csem_pkg::RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [csem_pkg::RSP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                             take;

   assign rsp_empty = (cnt_ff == '0);
   assign rsp_data  = q_mem[rd_ptr_ff];
   assign take      = rsp_pop && !rsp_empty;
   // Room for two items: the back end may push two per command
   assign room2     = (cnt_ff <= csem_pkg::RSP_CNT_W'(csem_pkg::RSP_DEPTH - 2));

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign cnt_in    = cnt_ff + csem_pkg::RSP_CNT_W'(push) - csem_pkg::RSP_CNT_W'(take);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_IMPLIES(a_rsp_no_overflow, clock, reset, push,
                   cnt_ff < csem_pkg::RSP_CNT_W'(csem_pkg::RSP_DEPTH))

endmodule

/* src/csem_back.sv */
`include "assert_macros.svh"

module csem_back #(
   parameter int TASKS      = 64,
   parameter int SEMAPHORES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_pop,
   input  csem_pkg::cmd_type  cmd_data,
   input  logic               room2,
   output logic               rsp_push,
   output csem_pkg::rsp_type  rsp_item
);

   localparam int SEM_W  = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
   localparam int TASK_W = $clog2(TASKS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_LINK = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   csem_pkg::cmd_type  cur_ff;

   logic [15:0]        count_mem [SEMAPHORES];
   logic [5:0]         head_mem  [SEMAPHORES];
   logic [5:0]         tail_mem  [SEMAPHORES];
   logic [5:0]         next_mem  [TASKS];
   logic [SEMAPHORES-1:0] cnt_vld_ff;

   logic [15:0]        count_rd_ff;
   logic               vld_rd_ff;
   logic [5:0]         head_rd_ff;
   logic [5:0]         tail_rd_ff;
   logic [5:0]         next_rd_ff;

   logic [SEM_W-1:0]   rd_sem;
   logic [SEM_W-1:0]   cur_sem;
   logic               start;
   logic [15:0]        old_cnt;
   logic [15:0]        new_cnt;
   logic               cnt_we;
   logic [15:0]        cnt_wdata;
   logic               head_we;
   logic [5:0]         head_wdata;
   logic               tail_we;
   logic               next_we;
   logic               link_rd;

   assign rd_sem  = SEM_W'(cmd_data.sem_id);
   assign cur_sem = SEM_W'(cur_ff.sem_id);
   assign start   = (state_ff == ST_IDLE) && cmd_valid && room2;
   assign cmd_pop = start;
   // Entries never written since reset read as zero
   assign old_cnt = vld_rd_ff ? count_rd_ff : '0;

   always_comb begin
      state_in   = state_ff;
      new_cnt    = old_cnt;
      cnt_we     = 1'b0;
      cnt_wdata  = old_cnt;
      head_we    = 1'b0;
      head_wdata = cur_ff.task_id;
      tail_we    = 1'b0;
      next_we    = 1'b0;
      link_rd    = 1'b0;
      rsp_push   = 1'b0;
      rsp_item.release_task = cur_ff.task_id;
      rsp_item.last         = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (cur_ff.op)
               csem_pkg::OP_WAIT: begin
                  // Drop a wait at the minimum count
                  if (old_cnt != csem_pkg::CNT_MIN) begin
                     new_cnt   = old_cnt - 16'd1;
                     cnt_we    = 1'b1;
                     cnt_wdata = new_cnt;
                     if (!new_cnt[15]) begin
                        rsp_push = 1'b1;
                     end else begin
                        // Append the caller: start a queue or link behind the tail
                        head_we = !old_cnt[15];
                        next_we = old_cnt[15];
                        tail_we = 1'b1;
                     end
                  end
               end
               csem_pkg::OP_SIGNAL: begin
                  new_cnt   = (old_cnt == csem_pkg::CNT_MAX) ? old_cnt : old_cnt + 16'd1;
                  cnt_we    = 1'b1;
                  cnt_wdata = new_cnt;
                  rsp_push  = 1'b1;
                  if (new_cnt[15] || new_cnt == '0) begin
                     // Signaller first, queue head follows from the link state
                     rsp_item.last = 1'b0;
                     link_rd       = 1'b1;
                     state_in      = ST_LINK;
                  end
               end
               csem_pkg::OP_INIT: begin
                  cnt_we    = 1'b1;
                  cnt_wdata = {1'b0, cur_ff.initial_count};
               end
               default: begin
                  cnt_we = 1'b0;
               end
            endcase
         end
         ST_LINK: begin
            // Release the old head and advance the head to its successor
            rsp_push              = 1'b1;
            rsp_item.release_task = head_rd_ff;
            rsp_item.last         = 1'b1;
            head_we               = 1'b1;
            head_wdata            = next_rd_ff;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (cnt_we) begin
            cnt_vld_ff[cur_sem] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cur_ff      <= cmd_data;
         count_rd_ff <= count_mem[rd_sem];
         vld_rd_ff   <= cnt_vld_ff[rd_sem];
         head_rd_ff  <= head_mem[rd_sem];
         tail_rd_ff  <= tail_mem[rd_sem];
      end
      if (link_rd) begin
         next_rd_ff <= next_mem[TASK_W'(head_rd_ff)];
      end
      if (cnt_we) begin
         count_mem[cur_sem] <= cnt_wdata;
      end
      if (head_we) begin
         head_mem[cur_sem] <= head_wdata;
      end
      if (tail_we) begin
         tail_mem[cur_sem] <= cur_ff.task_id;
      end
      if (next_we) begin
         next_mem[TASK_W'(tail_rd_ff)] <= cur_ff.task_id;
      end
   end

   `ASSERT_IMPLIES(a_back_pop_idle, clock, reset, cmd_pop,
                   state_ff == ST_IDLE && room2 && cmd_valid)
   `ASSERT_NEXT(a_back_link_follows, clock, reset,
                state_ff == ST_EXEC && link_rd, state_ff == ST_LINK && rsp_push)
   `ASSERT_IMPLIES(a_back_link_origin, clock, reset, state_ff == ST_LINK,
                   $past(state_ff) == ST_EXEC && cur_ff.op == csem_pkg::OP_SIGNAL)

endmodule

/* src/counting_semaphore_wait_queue.sv */
// Counting semaphore table with a FIFO wait queue per semaphore.
// Requests enter through a queue-style port: drive req_data and raise req_push;
// the item is taken on a clock edge where req_full is low. Commands are wait,
// signal and init; unknown codes and out-of-range semaphore or task ids are
// taken and discarded. Released task numbers come out through rsp_data while
// rsp_empty is low and are taken on an edge where rsp_pop is high. A signal
// that wakes a waiter yields two items, the signaller first; last marks the
// final item of a request. Blocked waits and inits yield nothing.
// The back end takes a command from the command queue when it is idle and the
// result queue has room for two items, reads the tables into registers, then
// updates them and pushes the first result; the dequeued waiter of a signal
// follows from the link state, after a second read of the link table. The
// back end takes no new command until it is through with the last one.
// A stalled result consumer backs up the four-entry result queue; the back end
// stops once fewer than two entries are free, the two-entry command queue
// fills, and req_full rises.
// Reset (synchronous, active high) empties both queues and sets every count
// to zero at once through per-semaphore valid bits; queue links need no clear.
module counting_semaphore_wait_queue #(
   parameter int TASKS      = 64,
   parameter int SEMAPHORES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  csem_pkg::req_type  req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output csem_pkg::rsp_type  rsp_data
);

   // Front to back command queue handshake
   logic               cmd_valid;
   logic               cmd_pop;
   csem_pkg::cmd_type  cmd_data;

   // Back to result queue
   logic               room2;
   logic               rsp_push;
   csem_pkg::rsp_type  rsp_item;

   // Accept, decode and filter requests; hold them in a short queue
   csem_front #(
      .TASKS      (TASKS),
      .SEMAPHORES (SEMAPHORES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   // Read-modify-write of the count, head, tail and link tables
   csem_back #(
      .TASKS      (TASKS),
      .SEMAPHORES (SEMAPHORES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .room2     (room2),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item)
   );

   // Hold released tasks until the consumer pops them
   csem_rsp_q u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_item),
      .room2     (room2),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
